// ===== src/ais_pkg.sv =====
// Package: shared constants, types and cell control for the ascending sorter.
package ais_pkg;

  localparam int unsigned COUNT_DEF = 64;
  localparam int unsigned DATA_W    = 32;

  typedef enum logic {
    ST_LOAD  = 1'b0,
    ST_DRAIN = 1'b1
  } state_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;    // insert the broadcast value at its ordered place
    logic shift;  // move every entry one cell toward the head
  } cell_ctrl_t;

endpackage

// ===== src/ais_cell.sv =====
// Module: one cell of the ordered insertion chain.
module ais_cell (
  input  logic                            clk,
  input  ais_pkg::cell_ctrl_t             ctrl,
  input  logic                            occupied,
  input  logic signed [ais_pkg::DATA_W-1:0] in_value,
  input  logic                            prev_gt,
  input  logic signed [ais_pkg::DATA_W-1:0] prev_data,
  input  logic signed [ais_pkg::DATA_W-1:0] next_data,
  output logic                            gt,
  output logic signed [ais_pkg::DATA_W-1:0] data
);

  logic signed [ais_pkg::DATA_W-1:0] data_r;
  logic signed [ais_pkg::DATA_W-1:0] data_nxt;

  // An empty cell counts as larger than anything.
  assign gt   = !occupied || (data_r > in_value);
  assign data = data_r;

  always_comb begin
    data_nxt = data_r;
    if (ctrl.shift) begin
      data_nxt = next_data;
    end else if (ctrl.ins && prev_gt) begin
      data_nxt = prev_data;   // make room: take the neighbor's entry
    end else if (ctrl.ins && gt) begin
      data_nxt = in_value;    // first larger cell: hold the new value
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

// ===== src/ascending_integer_sorter.sv =====
// Top level: ascending sorter built from a chain of insertion cells.
//
// Usage:
//   The input channel (in_valid / in_stall, in_value, in_last) takes one
//   signed 32-bit value per beat. Each accepted value drops straight into its
//   ordered place in a row of COUNT cells, so loading runs at one beat per
//   cycle. Values that arrive once all cells are full are dropped and the
//   run is marked as overflowed.
//   The beat with in_last set ends the set. From the next cycle the block
//   holds in_stall high and drains the chain head first, one result beat per
//   cycle while the receiver does not stall, on the output channel (out_valid /
//   out_stall, out_sorted_value, out_end_of_run, out_overflow). out_end_of_run
//   marks the largest value; out_overflow is set on every beat of a run that
//   lost values. The last beat moves the state register to drain; the head then
//   passes into the single output register that the chain shifts into, and the
//   first result beat is valid from that register.
//   When the receiver stalls, the output beat holds and the chain holds.
//   The input reopens in the cycle after the final beat is loaded into the
//   output register, so a new set can load while that beat still waits.
//   Reset (rst_n low, synchronous) empties the chain and clears the flags.
module ascending_integer_sorter #(
  parameter int unsigned COUNT = ais_pkg::COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [ais_pkg::DATA_W-1:0] in_value,
  input  logic                              in_last,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [ais_pkg::DATA_W-1:0] out_sorted_value,
  output logic                              out_end_of_run,
  output logic                              out_overflow
);

  localparam int unsigned CNT_W = $clog2(COUNT + 1);

  ais_pkg::state_t     state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                ovf_r, ovf_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic signed [ais_pkg::DATA_W-1:0] out_value_r;
  logic                out_eor_r;
  logic                out_ovf_r;

  logic                in_accept;
  logic                full;
  logic                out_load;
  logic                drain_done;
  ais_pkg::cell_ctrl_t ctrl;

  logic                              cell_gt   [COUNT];
  logic signed [ais_pkg::DATA_W-1:0] cell_data [COUNT];

  assign in_accept  = in_valid && !in_stall;
  assign full       = (count_r == CNT_W'(COUNT));
  // While draining, pull the head into the output register whenever it is free or being taken.
  assign out_load   = (state_r == ais_pkg::ST_DRAIN) && (!out_valid_r || !out_stall);
  assign drain_done = out_load && (count_r == CNT_W'(1));

  assign ctrl.ins   = in_accept && !full;
  assign ctrl.shift = out_load;

  // Chain of cells; occupancy follows from the fill count.
  for (genvar i = 0; i < COUNT; i++) begin : g_cell
    logic                              prev_gt;
    logic signed [ais_pkg::DATA_W-1:0] prev_data;
    logic signed [ais_pkg::DATA_W-1:0] next_data;

    if (i == 0) begin : g_head
      assign prev_gt   = 1'b0;
      assign prev_data = cell_data[0];
    end else begin : g_body
      assign prev_gt   = cell_gt[i-1];
      assign prev_data = cell_data[i-1];
    end

    if (i == COUNT - 1) begin : g_tail
      assign next_data = cell_data[i];
    end else begin : g_link
      assign next_data = cell_data[i+1];
    end

    ais_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occupied  (count_r > CNT_W'(i)),
      .in_value  (in_value),
      .prev_gt   (prev_gt),
      .prev_data (prev_data),
      .next_data (next_data),
      .gt        (cell_gt[i]),
      .data      (cell_data[i])
    );
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ais_pkg::ST_LOAD: begin
        if (in_accept && in_last) begin
          state_nxt = ais_pkg::ST_DRAIN;
        end
      end
      ais_pkg::ST_DRAIN: begin
        if (drain_done) begin
          state_nxt = ais_pkg::ST_LOAD;
        end
      end
      default: state_nxt = ais_pkg::ST_LOAD;
    endcase
  end

  // State outputs: hold the input while draining.
  always_comb begin
    unique case (state_r)
      ais_pkg::ST_LOAD:  in_stall = 1'b0;
      ais_pkg::ST_DRAIN: in_stall = 1'b1;
      default:           in_stall = 1'b1;
    endcase
  end

  // Fill count and overflow mark.
  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    if (ctrl.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (out_load) begin
      count_nxt = count_r - CNT_W'(1);
    end
    if (in_accept && full) begin
      ovf_nxt = 1'b1;
    end
    if (drain_done) begin
      ovf_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ais_pkg::ST_LOAD;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output beat payload; advance only on a load.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value_r <= cell_data[0];
      out_eor_r   <= (count_r == CNT_W'(1));
      out_ovf_r   <= ovf_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sorted_value = out_value_r;
  assign out_end_of_run   = out_eor_r;
  assign out_overflow     = out_ovf_r;

  // Fill count never exceeds the chain length.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(COUNT))
    else $error("fill count beyond chain length");

  // A drain always has at least one entry to emit.
  a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ais_pkg::ST_DRAIN) |-> (count_r != '0))
    else $error("drain with empty chain");

  // Draining starts only after a last beat was accepted.
  a_drain_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == ais_pkg::ST_DRAIN) |-> $past(in_accept && in_last))
    else $error("drain started without a last beat");

  // The head leaves the chain only into a free or emptying output register.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> $stable(out_value_r))
    else $error("pending output beat overwritten");

endmodule

// ===== test/tb_ascending_integer_sorter.sv =====
// Testbench for the ascending integer sorter: random sets in, sorted beats checked out.
`timescale 1ns / 100ps

module tb_ascending_integer_sorter;

  localparam int unsigned NCELLS     = ais_pkg::COUNT_DEF;
  localparam int          IDLE_LIMIT = 2000;  // cycles without any accepted beat
  localparam int          HOLDOFF    = 200;   // long receiver hold-off, in cycles
  localparam int          HOLD_AT    = 100;   // results seen before the hold-off starts
  localparam int          CALM_TAIL  = 50;    // pending beats left when idling stops
  localparam int          ITEM_GOAL  = 410;

  typedef logic signed [ais_pkg::DATA_W-1:0] word_t;

  localparam word_t WORD_MIN = {1'b1, {(ais_pkg::DATA_W-1){1'b0}}};
  localparam word_t WORD_MAX = {1'b0, {(ais_pkg::DATA_W-1){1'b1}}};

  // One input beat as queued for the driver; hold makes the driver wait
  // until every expected result has drained before offering it.
  typedef struct {
    word_t value;
    logic  last;
    bit    hold;
  } in_beat_t;

  // One expected output beat.
  typedef struct {
    word_t value;
    logic  end_of_run;
    logic  overflow;
  } sorted_beat_t;

  logic  clk       = 1'b0;
  logic  rst_n     = 1'b0;
  logic  in_valid  = 1'b0;
  logic  in_stall;
  word_t in_value  = '0;
  logic  in_last   = 1'b0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  word_t out_sorted_value;
  logic  out_end_of_run;
  logic  out_overflow;

  ascending_integer_sorter dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_value         (in_value),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sorted_value (out_sorted_value),
    .out_end_of_run   (out_end_of_run),
    .out_overflow     (out_overflow)
  );

  // 4 ns period: low half, then high half.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  in_beat_t     pending_beats[$];
  sorted_beat_t expected_sorted[$];
  int           errors = 0;
  bit           calm   = 1'b0;  // last stretch of the run: no idling on either side

  // ---------------------------------------------------------------------------
  // Sort model: its own copy of the cell contents, fill count and overflow flag.
  // ---------------------------------------------------------------------------
  word_t model_store [NCELLS];
  int    model_count = 0;
  logic  model_ovf   = 1'b0;

  // Take one accepted input beat; on a last beat, sort what is held and queue
  // one expected beat per held value, smallest first.
  task automatic sort_model_accept(input word_t v, input logic last);
    word_t key;
    int    i;
    int    j;
    if (model_count < NCELLS) begin
      model_store[model_count] = v;
      model_count++;
    end else begin
      model_ovf = 1'b1;  // full: drop the value, flag the run
    end
    if (last) begin
      // Plain insertion sort on signed words.
      for (j = 1; j < model_count; j++) begin
        key = model_store[j];
        i   = j;
        while (i > 0 && model_store[i-1] > key) begin
          model_store[i] = model_store[i-1];
          i--;
        end
        model_store[i] = key;
      end
      for (j = 0; j < model_count; j++)
        expected_sorted.push_back('{model_store[j], (j == model_count - 1), model_ovf});
      model_count = 0;
      model_ovf   = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  int queued_items = 0;

  task automatic push_beat(input word_t v, input logic last, input bit hold);
    pending_beats.push_back('{v, last, hold});
    queued_items++;
  endtask

  // Mix of full-range words, values near zero, the extremes and repeats.
  function automatic word_t pick_value(input word_t prev);
    case ($urandom_range(0, 9))
      0:       return WORD_MIN;
      1:       return WORD_MAX;
      2, 3:    return prev;
      4, 5:    return word_t'($urandom_range(0, 40)) - 20;
      default: return word_t'($urandom);
    endcase
  endfunction

  task automatic push_set(input int n, input bit hold);
    word_t v;
    int    k;
    v = word_t'($urandom);
    for (k = 0; k < n; k++) begin
      v = pick_value(v);
      push_beat(v, (k == n - 1), hold && (k == 0));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offer pending beats, idle in short random bursts, hold a stalled
  // beat unchanged, feed the sort model with every accepted beat.
  // ---------------------------------------------------------------------------
  int       gap_left = 0;
  in_beat_t next_beat;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        sort_model_accept(in_value, in_last);
      calm <= (pending_beats.size() < CALM_TAIL);
      // Advance only when no beat is waiting on the channel.
      if (!in_valid || !in_stall) begin
        if (gap_left == 0 && !calm && $urandom_range(0, 6) == 0)
          gap_left = $urandom_range(1, 4);
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_beats.size() != 0 &&
                     !(pending_beats[0].hold && expected_sorted.size() != 0)) begin
          next_beat = pending_beats.pop_front();
          in_value <= next_beat.value;
          in_last  <= next_beat.last;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each accepted result beat against the oldest expectation,
  // stall in short random bursts, and once hold off for a long stretch so the
  // output beat holds and draining stops while the driver keeps offering.
  // ---------------------------------------------------------------------------
  int           results_seen = 0;
  int           hold_left    = 0;
  int           stall_left   = 0;
  sorted_beat_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (results_seen == HOLD_AT)
          hold_left = HOLDOFF;
        if (expected_sorted.size() == 0) begin
          $error("unexpected result beat: sorted_value %0d", out_sorted_value);
          errors++;
        end else begin
          want = expected_sorted.pop_front();
          if (out_sorted_value !== want.value) begin
            $error("sorted_value: expected %0d, actual %0d", want.value, out_sorted_value);
            errors++;
          end
          if (out_end_of_run !== want.end_of_run) begin
            $error("end_of_run: expected %0b, actual %0b", want.end_of_run, out_end_of_run);
            errors++;
          end
          if (out_overflow !== want.overflow) begin
            $error("overflow: expected %0b, actual %0b", want.overflow, out_overflow);
            errors++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 4) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run when nothing moves on either channel for too long.
  // ---------------------------------------------------------------------------
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $error("timeout: no beat accepted for %0d cycles", IDLE_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int n;
    // Single-value sets at the extremes and around zero.
    push_beat(WORD_MIN, 1'b1, 1'b0);
    push_beat(WORD_MAX, 1'b1, 1'b0);
    push_beat(0, 1'b1, 1'b0);
    push_beat(-1, 1'b1, 1'b0);
    // Mixed signs around zero and both extremes.
    push_beat(WORD_MAX, 1'b0, 1'b0);
    push_beat(WORD_MIN, 1'b0, 1'b0);
    push_beat(0, 1'b0, 1'b0);
    push_beat(-1, 1'b0, 1'b0);
    push_beat(1, 1'b1, 1'b0);
    // Equal values land next to each other.
    push_beat(7, 1'b0, 1'b0);
    push_beat(7, 1'b0, 1'b0);
    push_beat(-3, 1'b0, 1'b0);
    push_beat(7, 1'b0, 1'b0);
    push_beat(-3, 1'b1, 1'b0);
    // Strictly descending input.
    push_beat(5, 1'b0, 1'b0);
    push_beat(4, 1'b0, 1'b0);
    push_beat(3, 1'b0, 1'b0);
    push_beat(2, 1'b0, 1'b0);
    push_beat(1, 1'b1, 1'b0);
    // Duplicated extremes.
    push_beat(WORD_MAX, 1'b0, 1'b0);
    push_beat(WORD_MIN, 1'b0, 1'b0);
    push_beat(WORD_MAX, 1'b0, 1'b0);
    push_beat(WORD_MIN, 1'b1, 1'b0);

    // A set that fills every cell exactly, then one that drops its tail,
    // last beat included; the second waits for the chain to drain first.
    push_set(NCELLS, 1'b0);
    push_set(NCELLS + 2, 1'b1);
    // Random sets: mostly short, now and then full, near full or overflowing.
    while (queued_items < ITEM_GOAL) begin
      case ($urandom_range(0, 19))
        0:       n = NCELLS;
        1:       n = $urandom_range(NCELLS + 1, NCELLS + 8);
        2:       n = $urandom_range(NCELLS - 24, NCELLS - 1);
        default: n = $urandom_range(1, 10);
      endcase
      push_set(n, ($urandom_range(0, 11) == 0));
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every beat to be taken, then for the last results to drain.
    while (pending_beats.size() != 0 || in_valid)
      @(posedge clk);
    while (expected_sorted.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
